>>> rtl/iesu_pkg.sv
// ---------------------------------------------------------------------------
// iesu_pkg
// Shared constants, types and state encoding for the exchange sort unit.
// ---------------------------------------------------------------------------
package iesu_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_I,
		ST_LD_I,
		ST_CMP,
		ST_WB_I,
		ST_EM_RD,
		ST_EM_OUT
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		state_t state;
		cnt_t   count;
	} status_t;

endpackage

>>> rtl/integer_exchange_sort_unit.sv
// ---------------------------------------------------------------------------
// integer_exchange_sort_unit
// Sorts a list of signed 32-bit integers in ascending order.
//
// The s_ channel takes one element per transaction; s_tlast closes the list.
// Up to 64 elements are held; further ones are dropped and every result of
// that list then carries m_tuser set. While loading, one element is taken
// per cycle. After the closing transaction s_tready stays low while the
// exchange sort runs over the element store: one compare-swap per cycle on
// the single read and single write port, plus a load (ST_LD_I) and a
// write-back (ST_WB_I) of element i per outer pass. The sorted list then
// leaves on the m_ channel, read in ST_EM_RD and sent in ST_EM_OUT, with
// m_tlast on the final element. A stall on m_tready holds the result
// register and the emission. The final result sits in its own register, so
// loading of the next list starts while it waits. Reset clears the fill
// count, the drop flag and the result valid; the store needs no clearing.
// ---------------------------------------------------------------------------
module integer_exchange_sort_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // [31:0] value
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,  // [31:0] value_res
	output logic                 m_tlast,
	output logic                 m_tuser   // [0] truncated
);

	iesu_pkg::mem_req_t req;
	iesu_pkg::data_t    rd_data;
	iesu_pkg::status_t  sts;

	iesu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.req      (req),
		.rd_data  (rd_data),
		.sts      (sts)
	);

	iesu_ram u_ram (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	a_close_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still taken after list closed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= iesu_pkg::CNT_W'(iesu_pkg::MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.state != iesu_pkg::ST_LOAD) |-> (sts.count != '0))
		else $error("sort or emission with an empty list");

	a_write_only_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we && sts.state != iesu_pkg::ST_LOAD) |->
			(iesu_pkg::CNT_W'(req.waddr) < sts.count))
		else $error("store write beyond the list");

endmodule

>>> rtl/iesu_ram.sv
// ---------------------------------------------------------------------------
// iesu_ram
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module iesu_ram (
	input  logic               clk,
	input  iesu_pkg::mem_req_t req,
	output iesu_pkg::data_t    rd_data
);

	iesu_pkg::data_t mem [iesu_pkg::MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

>>> rtl/iesu_ctrl.sv
// ---------------------------------------------------------------------------
// iesu_ctrl
// Sequencer: loads the list, runs the compare-swap passes over the store and
// drives the result register.
// ---------------------------------------------------------------------------
module iesu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  iesu_pkg::data_t     s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output iesu_pkg::data_t     m_tdata,
	output logic                m_tlast,
	output logic                m_tuser,
	output iesu_pkg::mem_req_t  req,
	input  iesu_pkg::data_t     rd_data,
	output iesu_pkg::status_t   sts
);

	iesu_pkg::state_t state_q, state_nxt;
	iesu_pkg::cnt_t   cnt_q, cnt_after, last_idx;
	iesu_pkg::addr_t  i_q, j_q, k_q;
	iesu_pkg::data_t  ri_q;
	logic             ovf_q;
	logic             out_valid_q, out_last_q, out_trunc_q;
	iesu_pkg::data_t  out_data_q;

	logic in_fire, has_room, j_end, i_end, k_end, swap, out_free, emit_fire;

	assign s_tready  = (state_q == iesu_pkg::ST_LOAD);
	assign in_fire   = s_tvalid && s_tready;
	assign has_room  = (cnt_q < iesu_pkg::CNT_W'(iesu_pkg::MAX_ITEMS));
	assign cnt_after = cnt_q + iesu_pkg::CNT_W'(has_room);
	assign last_idx  = cnt_q - iesu_pkg::CNT_W'(1);
	assign j_end     = (iesu_pkg::CNT_W'(j_q) == last_idx);
	assign k_end     = (iesu_pkg::CNT_W'(k_q) == last_idx);
	assign i_end     = (iesu_pkg::CNT_W'(i_q) + iesu_pkg::CNT_W'(2) == cnt_q);
	assign swap      = ($signed(ri_q) > $signed(rd_data));
	assign out_free  = !out_valid_q || m_tready;
	assign emit_fire = (state_q == iesu_pkg::ST_EM_OUT) && out_free;

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tlast   = out_last_q;
	assign m_tuser   = out_trunc_q;
	assign sts.state = state_q;
	assign sts.count = cnt_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			iesu_pkg::ST_LOAD: begin
				if (in_fire && s_tlast) begin
					state_nxt = (cnt_after < iesu_pkg::CNT_W'(2)) ?
						iesu_pkg::ST_EM_RD : iesu_pkg::ST_RD_I;
				end
			end
			iesu_pkg::ST_RD_I: state_nxt = iesu_pkg::ST_LD_I;
			iesu_pkg::ST_LD_I: state_nxt = iesu_pkg::ST_CMP;
			iesu_pkg::ST_CMP: begin
				if (j_end) begin
					state_nxt = iesu_pkg::ST_WB_I;
				end
			end
			iesu_pkg::ST_WB_I: begin
				state_nxt = i_end ? iesu_pkg::ST_EM_RD : iesu_pkg::ST_LD_I;
			end
			iesu_pkg::ST_EM_RD: state_nxt = iesu_pkg::ST_EM_OUT;
			iesu_pkg::ST_EM_OUT: begin
				if (out_free) begin
					state_nxt = k_end ? iesu_pkg::ST_LOAD : iesu_pkg::ST_EM_RD;
				end
			end
			default: state_nxt = iesu_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			iesu_pkg::ST_LOAD: begin
				req.we    = in_fire && has_room;
				req.waddr = cnt_q[iesu_pkg::ADDR_W-1:0];
				req.wdata = s_tdata;
			end
			iesu_pkg::ST_RD_I: begin
				req.re    = 1'b1;
				req.raddr = i_q;
			end
			iesu_pkg::ST_LD_I: begin
				req.re    = 1'b1;
				req.raddr = i_q + iesu_pkg::ADDR_W'(1);
			end
			iesu_pkg::ST_CMP: begin
				req.we    = swap;
				req.waddr = j_q;
				req.wdata = ri_q;
				req.re    = !j_end;
				req.raddr = j_q + iesu_pkg::ADDR_W'(1);
			end
			iesu_pkg::ST_WB_I: begin
				req.we    = 1'b1;
				req.waddr = i_q;
				req.wdata = ri_q;
				req.re    = !i_end;
				req.raddr = i_q + iesu_pkg::ADDR_W'(1);
			end
			iesu_pkg::ST_EM_RD: begin
				req.re    = 1'b1;
				req.raddr = k_q;
			end
			iesu_pkg::ST_EM_OUT: req = '0;
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iesu_pkg::ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				if (has_room) begin
					cnt_q <= cnt_after;
				end else begin
					ovf_q <= 1'b1;
				end
				i_q <= '0;
				k_q <= '0;
			end
			if (state_q == iesu_pkg::ST_LD_I) begin
				j_q <= i_q + iesu_pkg::ADDR_W'(1);
			end
			if (state_q == iesu_pkg::ST_CMP) begin
				j_q <= j_q + iesu_pkg::ADDR_W'(1);
			end
			if (state_q == iesu_pkg::ST_WB_I) begin
				i_q <= i_q + iesu_pkg::ADDR_W'(1);
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				if (k_end) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					k_q <= k_q + iesu_pkg::ADDR_W'(1);
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == iesu_pkg::ST_LD_I || (state_q == iesu_pkg::ST_CMP && swap)) begin
			ri_q <= rd_data;
		end
		if (emit_fire) begin
			out_data_q  <= rd_data;
			out_last_q  <= k_end;
			out_trunc_q <= ovf_q;
		end
	end

endmodule

>>> verif/iesu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iesu_checker
// Watches both stream channels of the exchange sort unit. Every accepted
// input transaction up to capacity goes into a copy of the store; a closing
// transaction sorts that copy and queues the sorted list. Every accepted
// output transaction is compared field by field with the oldest queued one.
// ---------------------------------------------------------------------------
module iesu_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  iesu_pkg::data_t s_tdata,   // [31:0] value
	input  logic            s_tlast,
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  iesu_pkg::data_t m_tdata,   // [31:0] value_res
	input  logic            m_tlast,
	input  logic            m_tuser,   // [0] truncated
	output int              mismatches,
	output int              pending
);

	typedef struct packed {
		iesu_pkg::data_t value;
		logic            last;
		logic            truncated;
	} sorted_elem_t;

	iesu_pkg::data_t held [iesu_pkg::MAX_ITEMS];
	int              held_count;
	logic            dropped;
	sorted_elem_t    sorted_q[$];
	sorted_elem_t    oldest;

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic sort_and_queue();
		iesu_pkg::data_t swap;
		sorted_elem_t    elem;
		for (int i = 0; i + 1 < held_count; i++) begin
			for (int j = i + 1; j < held_count; j++) begin
				if ($signed(held[i]) > $signed(held[j])) begin
					swap    = held[i];
					held[i] = held[j];
					held[j] = swap;
				end
			end
		end
		for (int k = 0; k < held_count; k++) begin
			elem.value     = held[k];
			elem.last      = (k + 1 == held_count);
			elem.truncated = dropped;
			sorted_q = {sorted_q, elem};
		end
		held_count = 0;
		dropped    = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			dropped    = 1'b0;
			mismatches = 0;
			sorted_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (held_count < iesu_pkg::MAX_ITEMS) begin
					held[held_count] = s_tdata;
					held_count++;
				end else begin
					dropped = 1'b1;
				end
				if (s_tlast)
					sort_and_queue();
			end
			if (m_tvalid && m_tready) begin
				if (sorted_q.size() == 0) begin
					note_mismatch($sformatf("result %0d with nothing pending",
						$signed(m_tdata)));
				end else begin
					oldest = sorted_q.pop_front();
					if (m_tdata !== oldest.value)
						note_mismatch($sformatf("value %0d, want %0d",
							$signed(m_tdata), $signed(oldest.value)));
					if (m_tlast !== oldest.last)
						note_mismatch($sformatf("tlast %b, want %b", m_tlast, oldest.last));
					if (m_tuser !== oldest.truncated)
						note_mismatch($sformatf("truncated %b, want %b",
							m_tuser, oldest.truncated));
				end
			end
		end
		pending = sorted_q.size();
	end

endmodule

>>> verif/tb_integer_exchange_sort_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_integer_exchange_sort_unit
// Stimulus and verdict for the exchange sort unit. A few directed lists
// cover extreme values, duplicates, sorted and reversed order; random lists
// of mixed length follow, some filling the store and some overflowing it.
// Both sides idle in short random bursts; the checker does the comparing.
// ---------------------------------------------------------------------------
module tb_integer_exchange_sort_unit;

	localparam int ITEM_TARGET = 470;
	localparam int CALM_FROM   = 400;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	iesu_pkg::data_t s_tdata;
	logic            s_tlast;
	logic            m_tvalid;
	logic            m_tready;
	iesu_pkg::data_t m_tdata;
	logic            m_tlast;
	logic            m_tuser;
	int              mismatches;
	int              pending;

	int              sent;
	bit              calm;
	bit              quiet;
	iesu_pkg::data_t pattern[$];

	integer_exchange_sort_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	iesu_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_integer_exchange_sort_unit NOT OK");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm || quiet || $urandom_range(0, 4) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end
		end
	end

	function automatic iesu_pkg::data_t pick_value();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 6)
			return iesu_pkg::data_t'($urandom);
		if (kind < 9)
			return iesu_pkg::data_t'($urandom_range(0, 15) - 8);
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h8000_0001;
			default: return 32'h7fff_fffe;
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input iesu_pkg::data_t value, input logic closes);
		if (!(calm || quiet) && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= closes;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_pattern();
		for (int k = 0; k < pattern.size(); k++)
			send_item(pattern[k], k == pattern.size() - 1);
	endtask

	task automatic send_random_list(input int len);
		for (int k = 0; k < len; k++)
			send_item(pick_value(), k == len - 1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int r;
		int len;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		sent     = 0;
		calm     = 1'b0;
		quiet    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		pattern = '{32'd42};
		send_pattern();
		pattern = '{32'h7fff_ffff, 32'h8000_0000};
		send_pattern();
		pattern = '{32'h0, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h0};
		send_pattern();
		pattern = '{32'd7, 32'd7, 32'd7};
		send_pattern();
		pattern = '{32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe, 32'h7fff_ffff};
		send_pattern();
		pattern = '{32'd9, 32'd5, 32'd3, 32'hffff_fffd, 32'h8000_0000};
		send_pattern();
		pattern = '{32'h5555_5555, 32'haaaa_aaaa};
		send_pattern();
		drain();

		while (sent < ITEM_TARGET) begin
			calm  = (sent >= CALM_FROM);
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 8);
			else if (r < 80)
				len = $urandom_range(9, 63);
			else if (r < 90)
				len = iesu_pkg::MAX_ITEMS;
			else
				len = $urandom_range(iesu_pkg::MAX_ITEMS + 1, iesu_pkg::MAX_ITEMS + 8);
			send_random_list(len);
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_integer_exchange_sort_unit OK");
		else
			$display("tb_integer_exchange_sort_unit NOT OK");
		$finish;
	end

endmodule
